// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CHK_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define CHK_IMPLY(label, ck, rn, ante, cons)
`define CHK_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ----- rtl/chtc_pkg.sv -----
// types, constants and helpers of the chained hash translation cache
package chtc_pkg;

  localparam int HOME_SLOTS     = 1024;
  localparam int OVERFLOW_SLOTS = 256;
  localparam int TOTAL_SLOTS    = HOME_SLOTS + OVERFLOW_SLOTS;
  localparam int IDX_W          = $clog2(TOTAL_SLOTS);

  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_INSERT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RESERVED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_INS_HOME,
    ST_INS_FREE,
    ST_INS_WALK
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] guest_address;
    logic [31:0] payload_in;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] payload_out;
    status_t     status;
  } out_word_t;

  typedef struct packed {
    logic valid;
    idx_t next;
  } link_t;

  typedef struct packed {
    idx_t        rd_addr;
    idx_t        wr_addr;
    logic        entry_we;
    logic        link_we;
    logic [31:0] wr_key;
    logic [31:0] wr_payload;
    link_t       wr_link;
  } store_req_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
    link_t       link;
  } store_rsp_t;

  function automatic idx_t home_of(logic [31:0] addr);
    logic [31:0] word;
    word = addr >> 2;
    return IDX_W'(word % 32'(HOME_SLOTS));
  endfunction

endpackage

// ----- rtl/chained_hash_translation_cache_core.sv -----
// chained hash translation cache: sequencer around the shared slot store
//
//   channel  ports                      handshake
//   input    in_word                    start high while busy low
//   result   out_word                   out_strobe high for one cycle
//
// after reset the block clears the slot store, one slot a cycle, all TOTAL_SLOTS (1280)
// slots with busy high. a reserved address is answered from idle, with busy low. a lookup
// reads the home slot, then one slot per chain hop; a home or a refused insert ends
// at the home slot; an overflow insert takes the free list head, writes the new slot, then
// walks the chain to its tail and links the new slot there. the one store read port sets
// the pace. the result receiver cannot stall; busy is high while other words are worked on.
`include "assert_macros.svh"

module chained_hash_translation_cache_core
  import chtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  state_t state_r, state_nxt;
  idx_t   clr_cnt_r, clr_cnt_nxt;
  idx_t   cur_idx_r, cur_idx_nxt;
  idx_t   slot_r, slot_nxt;
  idx_t   free_head_r, free_head_nxt;
  logic   free_empty_r, free_empty_nxt;
  logic   out_strobe_r, out_strobe_nxt;

  in_word_t  op_r, op_nxt;
  out_word_t out_word_r, out_word_nxt;

  store_req_t req;
  store_rsp_t rsp;

  logic key_match;
  logic home_empty;
  logic reserved_take;

  chtc_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // the compare unit on the store read key
  assign key_match  = (rsp.key == op_r.guest_address);
  assign home_empty = (rsp.key == EMPTY_KEY);

  assign reserved_take = start && !busy && (in_word.guest_address == EMPTY_KEY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      free_head_r  <= IDX_W'(HOME_SLOTS);
      free_empty_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      free_head_r  <= free_head_nxt;
      free_empty_r <= free_empty_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_idx_r  <= cur_idx_nxt;
    slot_r     <= slot_nxt;
    op_r       <= op_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_idx_nxt    = cur_idx_r;
    slot_nxt       = slot_r;
    free_head_nxt  = free_head_r;
    free_empty_nxt = free_empty_r;
    out_strobe_nxt = 1'b0;
    op_nxt         = op_r;
    out_word_nxt   = out_word_r;

    req            = '0;
    req.rd_addr    = cur_idx_r;
    req.wr_addr    = cur_idx_r;
    req.wr_key     = op_r.guest_address;
    req.wr_payload = op_r.payload_in;

    case (state_r)
      ST_CLEAR: begin
        // home slots empty with no link, overflow slots chained as free list
        req.wr_addr    = clr_cnt_r;
        req.entry_we   = 1'b1;
        req.link_we    = 1'b1;
        req.wr_key     = EMPTY_KEY;
        req.wr_payload = '0;
        if (clr_cnt_r >= IDX_W'(HOME_SLOTS) && clr_cnt_r != IDX_W'(TOTAL_SLOTS - 1)) begin
          req.wr_link.valid = 1'b1;
          req.wr_link.next  = clr_cnt_r + IDX_W'(1);
        end
        if (clr_cnt_r == IDX_W'(TOTAL_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt      = in_word;
          req.rd_addr = home_of(in_word.guest_address);
          cur_idx_nxt = home_of(in_word.guest_address);
          if (in_word.guest_address == EMPTY_KEY) begin
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '{hit: 1'b0, payload_out: '0, status: STATUS_RESERVED};
          end else if (in_word.func == FUNC_INSERT) begin
            state_nxt = ST_INS_HOME;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (key_match) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{hit: 1'b1, payload_out: rsp.payload, status: STATUS_OK};
        end else if (!rsp.link.valid) begin
          // an empty home slot never carries a link, so it ends here too
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{hit: 1'b0, payload_out: '0, status: STATUS_NOT_FOUND};
        end else begin
          req.rd_addr = rsp.link.next;
          cur_idx_nxt = rsp.link.next;
        end
      end
      ST_INS_HOME: begin
        if (home_empty) begin
          req.entry_we   = 1'b1;
          req.link_we    = 1'b1;
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{hit: 1'b1, payload_out: op_r.payload_in, status: STATUS_OK};
        end else if (free_empty_r) begin
          state_nxt      = ST_IDLE;
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{hit: 1'b0, payload_out: '0, status: STATUS_FULL};
        end else begin
          // read the link of the free list head
          req.rd_addr = free_head_r;
          slot_nxt    = free_head_r;
          state_nxt   = ST_INS_FREE;
        end
      end
      ST_INS_FREE: begin
        if (rsp.link.valid) begin
          free_head_nxt = rsp.link.next;
        end else begin
          free_empty_nxt = 1'b1;
          free_head_nxt  = '0;
        end
        req.wr_addr  = slot_r;
        req.entry_we = 1'b1;
        req.link_we  = 1'b1;
        // start the tail walk back at the home slot
        req.rd_addr  = cur_idx_r;
        state_nxt    = ST_INS_WALK;
      end
      ST_INS_WALK: begin
        if (!rsp.link.valid) begin
          req.link_we       = 1'b1;
          req.wr_link.valid = 1'b1;
          req.wr_link.next  = slot_r;
          state_nxt         = ST_IDLE;
          out_strobe_nxt    = 1'b1;
          out_word_nxt      = '{hit: 1'b1, payload_out: op_r.payload_in, status: STATUS_OK};
        end else begin
          req.rd_addr = rsp.link.next;
          cur_idx_nxt = rsp.link.next;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `CHK_IMPLY(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `CHK_NEXT(a_reserved, clk, rst_n, reserved_take, out_strobe && out_word.status == STATUS_RESERVED)
  `CHK_IMPLY(a_hit_ok, clk, rst_n, out_strobe, out_word.hit == (out_word.status == STATUS_OK))
  `CHK_IMPLY(a_free_empty_head, clk, rst_n, free_empty_r, free_head_r == '0)

endmodule

// ----- rtl/chtc_store.sv -----
// slot store: key, payload and link memories with one registered read port
module chtc_store
  import chtc_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic [31:0] key_mem     [TOTAL_SLOTS];
  logic [31:0] payload_mem [TOTAL_SLOTS];
  link_t       link_mem    [TOTAL_SLOTS];

  store_rsp_t rsp_r;

  always_ff @(posedge clk) begin
    if (req.entry_we) begin
      key_mem[req.wr_addr]     <= req.wr_key;
      payload_mem[req.wr_addr] <= req.wr_payload;
    end
    if (req.link_we) begin
      link_mem[req.wr_addr] <= req.wr_link;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r.key     <= key_mem[req.rd_addr];
    rsp_r.payload <= payload_mem[req.rd_addr];
    rsp_r.link    <= link_mem[req.rd_addr];
  end

  assign rsp = rsp_r;

endmodule
